>>> rtl/core/mbcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcr_pkg
// Shared widths, register codes and saturation helpers for the mesh
// bounding-box center/rescale block.
// ----------------------------------------------------------------------------
package mbcr_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 32;
  localparam int NUM_AXES     = 3;
  localparam int TGT_W        = COORD_BITS - 1;          // target size width
  localparam int MAG_W        = COORD_BITS + 1;          // centered magnitude
  localparam int DIVD_W       = MAG_W + TGT_W;           // product / dividend
  localparam int DCNT_W       = $clog2(DIVD_W);
  localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = NUM_AXES * COORD_BITS;

  localparam int CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd2;

  localparam logic [TGT_W-1:0]      TARGET_RST = TGT_W'(65536);
  localparam logic [COORD_BITS-1:0] COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};

  // clamp a one-bit-wider signed value into the coordinate range
  function automatic logic [COORD_BITS-1:0] sat_wide(logic [MAG_W-1:0] v);
    return (v[MAG_W-1] == v[MAG_W-2]) ? v[COORD_BITS-1:0]
         : (v[MAG_W-1] ? COORD_MIN : COORD_MAX);
  endfunction

  // sign-magnitude quotient back to a clamped signed coordinate
  function automatic logic [COORD_BITS-1:0] sat_scaled(logic neg, logic [DIVD_W-1:0] q);
    if (!neg) begin
      return (|q[DIVD_W-1:COORD_BITS-1]) ? COORD_MAX : q[COORD_BITS-1:0];
    end
    return ((|q[DIVD_W-1:COORD_BITS]) || (q[COORD_BITS-1] && (|q[COORD_BITS-2:0])))
         ? COORD_MIN : (COORD_BITS'(0) - q[COORD_BITS-1:0]);
  endfunction

  // unsigned clamp for extents
  function automatic logic [COORD_BITS-1:0] sat_dim(logic [DIVD_W-1:0] q);
    return (|q[DIVD_W-1:COORD_BITS]) ? {COORD_BITS{1'b1}} : q[COORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/mbcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcr_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbcr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mbcr_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [mbcr_pkg::COORD_BITS-1:0] divisor_i,
  output logic [mbcr_pkg::DIVD_W-1:0]     quotient_o,
  output logic                           done_o
);
  import mbcr_pkg::*;

  logic                  busy_q, done_q;
  logic [DCNT_W-1:0]     cnt_q;
  logic [COORD_BITS-1:0] rem_q, dvsr_q;
  logic [DIVD_W-1:0]     quo_q;
  logic [COORD_BITS:0]   shl, diff;
  logic                  ge;

  assign shl  = {rem_q, quo_q[DIVD_W-1]};
  assign ge   = shl >= {1'b0, dvsr_q};
  assign diff = shl - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= ge ? diff[COORD_BITS-1:0] : shl[COORD_BITS-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> rtl/core/mesh_bbox_center_rescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_bbox_center_rescale
// Stores a mesh, finds its bounding box, optionally centers and rescales it,
// then streams the normalized vertices back out with the box extents.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  in      | in  | in_valid_i/in_stall_o | pos_x/y/z_i, last_vertex_i
//  out     | out | out_valid_o/out_stall_i | out_x/y/z_o, dim_x/y/z_o, last_out_o
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Loading takes one vertex per cycle; the store is a 64 x 96 single-port RAM.
//  After the last vertex the box is captured; with rescale active the extents
//  then pass through the multiply and the 64-step shared-divisor dividers,
//  one per axis, and each emitted vertex goes RAM read, center, multiply,
//  divide, output register; without rescale RAM read, center, output register.
//  Reset returns config to center on, rescale on, target 1.0; the store needs
//  no clearing pass. A stalled output holds; the input is stalled from the
//  final input vertex until the final result of the burst is taken.
// ----------------------------------------------------------------------------
module mesh_bbox_center_rescale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // vertex input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mbcr_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [mbcr_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [mbcr_pkg::COORD_BITS-1:0] pos_z_i,
  input  logic                           last_vertex_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mbcr_pkg::COORD_BITS-1:0] out_x_o,
  output logic [mbcr_pkg::COORD_BITS-1:0] out_y_o,
  output logic [mbcr_pkg::COORD_BITS-1:0] out_z_o,
  output logic [mbcr_pkg::COORD_BITS-1:0] dim_x_o,
  output logic [mbcr_pkg::COORD_BITS-1:0] dim_y_o,
  output logic [mbcr_pkg::COORD_BITS-1:0] dim_z_o,
  output logic                           last_out_o,
  // config write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbcr_pkg::TGT_W-1:0]      cfg_data_i
);
  import mbcr_pkg::*;

  typedef enum logic [7:0] {
    ST_LOAD = 8'b0000_0001,  // taking vertices
    ST_BOX  = 8'b0000_0010,  // extents, center, largest
    ST_RD   = 8'b0000_0100,  // RAM read issued
    ST_CTR  = 8'b0000_1000,  // center subtract
    ST_MUL  = 8'b0001_0000,  // magnitude * target
    ST_DGO  = 8'b0010_0000,  // launch dividers
    ST_DIV  = 8'b0100_0000,  // wait for quotient
    ST_OUT  = 8'b1000_0000   // result presented
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic             center_en_q, rescale_en_q;
  logic [TGT_W-1:0] target_q;

  // load tracking
  logic [CNT_W-1:0]      count_q;
  logic [COORD_BITS-1:0] min_q [NUM_AXES];
  logic [COORD_BITS-1:0] max_q [NUM_AXES];

  // per-mesh results
  logic [COORD_BITS-1:0] centre_q  [NUM_AXES];
  logic [COORD_BITS-1:0] dim_out_q [NUM_AXES];
  logic [COORD_BITS-1:0] largest_q;
  logic                  scale_q;
  logic [CNT_W-1:0]      n_q;
  logic                  dim_phase_q;

  // emit datapath
  logic [IDX_W-1:0]      rd_idx_q;
  logic [VTX_W-1:0]      rd_data_q;
  logic [MAG_W-1:0]      op_q   [NUM_AXES];
  logic                  neg_q  [NUM_AXES];
  logic [DIVD_W-1:0]     prod_q [NUM_AXES];
  logic [COORD_BITS-1:0] out_q  [NUM_AXES];
  logic                  last_q;

  logic [VTX_W-1:0] vmem [MAX_VERTICES];

  logic                  in_acc, store_ok;
  logic [COORD_BITS-1:0] pos_c   [NUM_AXES];
  logic [COORD_BITS-1:0] dim_c   [NUM_AXES];
  logic [COORD_BITS-1:0] centre_c[NUM_AXES];
  logic [MAG_W-1:0]      v_c     [NUM_AXES];
  logic [MAG_W-1:0]      mag_c   [NUM_AXES];
  logic [COORD_BITS-1:0] l01_c, largest_c;
  logic                  scale_c;
  logic [DIVD_W-1:0]     quo     [NUM_AXES];
  logic [NUM_AXES-1:0]   done_v;
  logic                  div_done;

  assign in_acc   = in_valid_i && (state_q == ST_LOAD);
  assign store_ok = count_q < CNT_W'(MAX_VERTICES);
  assign pos_c[0] = pos_x_i;
  assign pos_c[1] = pos_y_i;
  assign pos_c[2] = pos_z_i;

  // box math from the tracked min/max
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic [MAG_W-1:0] sum;
      sum         = {max_q[a][COORD_BITS-1], max_q[a]} + {min_q[a][COORD_BITS-1], min_q[a]};
      dim_c[a]    = max_q[a] - min_q[a];
      centre_c[a] = sum[MAG_W-1:1];  // floor of half
    end
    l01_c     = (dim_c[0] > dim_c[1]) ? dim_c[0] : dim_c[1];
    largest_c = (l01_c > dim_c[2]) ? l01_c : dim_c[2];
    scale_c   = rescale_en_q && (largest_c != '0);
  end

  // center subtract on the vertex just read back
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic [COORD_BITS-1:0] s;
      s        = rd_data_q[a*COORD_BITS +: COORD_BITS];
      v_c[a]   = {s[COORD_BITS-1], s}
               - (center_en_q ? {centre_q[a][COORD_BITS-1], centre_q[a]} : MAG_W'(0));
      mag_c[a] = v_c[a][MAG_W-1] ? (MAG_W'(0) - v_c[a]) : v_c[a];
    end
  end

  // one divider per axis, all sharing the largest extent as divisor
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mbcr_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (state_q == ST_DGO),
      .dividend_i (prod_q[a] + DIVD_W'(largest_q >> 1)),
      .divisor_i  (largest_q),
      .quotient_o (quo[a]),
      .done_o     (done_v[a])
    );
  end
  assign div_done = &done_v;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_acc && last_vertex_i) state_d = ST_BOX;
      ST_BOX:  state_d = scale_c ? ST_MUL : ST_RD;
      ST_RD:   state_d = ST_CTR;
      ST_CTR:  state_d = scale_q ? ST_MUL : ST_OUT;
      ST_MUL:  state_d = ST_DGO;
      ST_DGO:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = dim_phase_q ? ST_RD : ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = last_q ? ST_LOAD : ST_RD;
      default: state_d = ST_LOAD;
    endcase
  end

  // vertex store: written while loading, read one entry per emitted request
  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      vmem[count_q[IDX_W-1:0]] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (state_q == ST_RD) begin
      rd_data_q <= vmem[rd_idx_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      center_en_q  <= 1'b1;
      rescale_en_q <= 1'b1;
      target_q     <= TARGET_RST;
      count_q      <= '0;
      scale_q      <= 1'b0;
      n_q          <= '0;
      dim_phase_q  <= 1'b0;
      rd_idx_q     <= '0;
      last_q       <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a] <= '0;
        max_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CENTER:  center_en_q  <= cfg_data_i[0];
          CFG_RESCALE: rescale_en_q <= cfg_data_i[0];
          CFG_TARGET:  target_q     <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_LOAD: begin
          if (in_acc && store_ok) begin
            count_q <= count_q + 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
              if (count_q == '0 || $signed(pos_c[a]) < $signed(min_q[a])) min_q[a] <= pos_c[a];
              if (count_q == '0 || $signed(pos_c[a]) > $signed(max_q[a])) max_q[a] <= pos_c[a];
            end
          end
        end
        ST_BOX: begin
          // box captured; tracking cleared for the next mesh
          scale_q     <= scale_c;
          n_q         <= count_q;
          count_q     <= '0;
          dim_phase_q <= 1'b1;
          rd_idx_q    <= '0;
          for (int a = 0; a < NUM_AXES; a++) begin
            min_q[a] <= '0;
            max_q[a] <= '0;
          end
        end
        ST_CTR: begin
          dim_phase_q <= 1'b0;
          last_q      <= ({1'b0, rd_idx_q} + 1'b1) == n_q;
        end
        ST_OUT: begin
          if (!out_stall_i && !last_q) rd_idx_q <= rd_idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_BOX: begin
        largest_q <= largest_c;
        for (int a = 0; a < NUM_AXES; a++) begin
          centre_q[a]  <= centre_c[a];
          dim_out_q[a] <= dim_c[a];
          op_q[a]      <= MAG_W'(dim_c[a]);
          neg_q[a]     <= 1'b0;
        end
      end
      ST_CTR: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          op_q[a]  <= mag_c[a];
          neg_q[a] <= v_c[a][MAG_W-1];
          out_q[a] <= sat_wide(v_c[a]);
        end
      end
      ST_MUL: begin
        // 33 x 31 bit magnitude product
        for (int a = 0; a < NUM_AXES; a++) begin
          prod_q[a] <= DIVD_W'(op_q[a]) * DIVD_W'(target_q);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            if (dim_phase_q) dim_out_q[a] <= sat_dim(quo[a]);
            else             out_q[a]     <= sat_scaled(neg_q[a], quo[a]);
          end
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_OUT);
  assign cfg_ready_o = 1'b1;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign dim_x_o     = dim_out_q[0];
  assign dim_y_o     = dim_out_q[1];
  assign dim_z_o     = dim_out_q[2];
  assign last_out_o  = last_q;

endmodule

>>> rtl/core/mbcr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcr_chk
// Port-level checks for the mesh bounding-box center/rescale block.
// ----------------------------------------------------------------------------
module mbcr_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           last_vertex_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mbcr_pkg::COORD_BITS-1:0] out_x_o,
  input logic [mbcr_pkg::COORD_BITS-1:0] dim_x_o,
  input logic [mbcr_pkg::COORD_BITS-1:0] dim_y_o,
  input logic [mbcr_pkg::COORD_BITS-1:0] dim_z_o,
  input logic                           last_out_o
);
  import mbcr_pkg::*;

  // no result while vertices are being taken
  a_no_out_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("result shown while loading");

  // the closing vertex stops the input
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_vertex_i) |=> in_stall_o)
    else $error("input still open after last vertex");

  // extents are constant within a burst
  a_dims_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_out_o) |=>
      ($stable(dim_x_o) && $stable(dim_y_o) && $stable(dim_z_o)))
    else $error("extents changed inside a burst");

  // end of burst reopens the input
  a_reopen_after_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_out_o) |=> (!in_stall_o && !out_valid_o))
    else $error("input not reopened after final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_x_o) && $stable(last_out_o)))
    else $error("stalled result changed");

endmodule

bind mesh_bbox_center_rescale mbcr_chk u_mbcr_chk (.*);
